// ===== src/iplb_pkg.sv =====
// Shared types and constants for the IPv4 TCP load-balancer header rewrite.
`timescale 1ns / 1ps

package iplb_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BALANCER_ADDR    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKEND_ONE_ADDR = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKEND_TWO_ADDR = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CLIENT_ADDR      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BALANCER_MAC     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKEND_ONE_MAC  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKEND_TWO_MAC  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_CLIENT_MAC       = 3'd7;

    // Register reset values
    localparam logic [31:0] RST_BALANCER_ADDR    = 32'hAC11_0002;
    localparam logic [31:0] RST_BACKEND_ONE_ADDR = 32'hAC11_0003;
    localparam logic [31:0] RST_BACKEND_TWO_ADDR = 32'hAC11_0004;
    localparam logic [31:0] RST_CLIENT_ADDR      = 32'hAC11_0005;
    localparam logic [7:0]  RST_BALANCER_MAC     = 8'h02;
    localparam logic [7:0]  RST_BACKEND_ONE_MAC  = 8'h03;
    localparam logic [7:0]  RST_BACKEND_TWO_MAC  = 8'h04;
    localparam logic [7:0]  RST_CLIENT_MAC       = 8'h05;

    // Verdict codes
    localparam logic [1:0] VERDICT_DROP = 2'd0;
    localparam logic [1:0] VERDICT_PASS = 2'd1;
    localparam logic [1:0] VERDICT_TX   = 2'd2;

    // Header constants
    localparam logic [13:0] MIN_FRAME_BYTES = 14'd34;
    localparam logic [15:0] ETHER_IPV4      = 16'h0800;
    localparam logic [7:0]  PROTO_ICMP      = 8'd1;
    localparam logic [7:0]  PROTO_TCP       = 8'd6;

    // Configuration register set
    typedef struct packed {
        logic [31:0] balancer_addr;
        logic [31:0] backend_one_addr;
        logic [31:0] backend_two_addr;
        logic [31:0] client_addr;
        logic [7:0]  balancer_mac_low;
        logic [7:0]  backend_one_mac_low;
        logic [7:0]  backend_two_mac_low;
        logic [7:0]  client_mac_low;
    } cfg_t;

endpackage

// ===== src/ipv4_tcp_lb_header_rewrite.sv =====
// Top level: three-stage IPv4 TCP load-balancer header rewrite pipeline.
//
//   Channel   Handshake               Payload
//   in        in_valid / in_ready     frame_length .. pick_second (header summary)
//   out       out_valid / out_ready   verdict, addresses, MAC low bytes, checksum
//   cfg       cfg_wr_en               cfg_index, cfg_data (write only)
//
// One item per cycle unless the output stalls; each result leaves from stage three.
// Stage one classifies and sums the fixed header words, stage two rewrites the
// addresses and adds them in, stage three folds, inverts and holds the result.
// A stalled output holds each full stage with no empty stage after it; the rest move on.
// Reset empties the pipeline and loads the default addresses and MAC bytes.
`timescale 1ns / 1ps

module ipv4_tcp_lb_header_rewrite
    import iplb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input items
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [13:0]            frame_length,
    input  logic [15:0]            ether_type,
    input  logic [15:0]            version_tos,
    input  logic [15:0]            total_length,
    input  logic [15:0]            ident,
    input  logic [15:0]            flags_fragment,
    input  logic [7:0]             ttl,
    input  logic [7:0]             protocol,
    input  logic [31:0]            src_addr,
    input  logic [31:0]            dst_addr,
    input  logic                   pick_second,
    // result items
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             verdict,
    output logic [31:0]            out_src_addr,
    output logic [31:0]            out_dst_addr,
    output logic [7:0]             dst_mac_low,
    output logic [7:0]             src_mac_low,
    output logic [15:0]            header_checksum
);

    cfg_t cfg;

    iplb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Pipeline control
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_valid_next, s2_valid_next, s3_valid_next;
    logic s1_ready, s2_ready, s3_ready;
    logic s1_load, s2_load, s3_load;

    // Stage one payload
    logic [1:0]  s1_verdict_reg;
    logic [31:0] s1_new_dst_reg;
    logic [7:0]  s1_new_mac_reg;
    logic [18:0] s1_psum_reg;
    logic [31:0] s1_src_reg;
    logic [31:0] s1_dst_reg;

    // Stage two payload
    logic [1:0]  s2_verdict_reg;
    logic [31:0] s2_src_reg;
    logic [31:0] s2_dst_reg;
    logic [7:0]  s2_dmac_reg;
    logic [7:0]  s2_smac_reg;
    logic [19:0] s2_sum_reg;

    // Stage three (output) payload
    logic [1:0]  s3_verdict_reg;
    logic [31:0] s3_src_reg;
    logic [31:0] s3_dst_reg;
    logic [7:0]  s3_dmac_reg;
    logic [7:0]  s3_smac_reg;
    logic [15:0] s3_csum_reg;

    // Stage one logic
    logic [1:0]  c_verdict;
    logic [31:0] c_new_dst;
    logic [7:0]  c_new_mac;
    logic [18:0] c_psum;

    // Stage two logic
    logic        s2_tx;
    logic [19:0] c_sum;

    // Stage three logic
    logic [16:0] c_fold1;
    logic [15:0] c_fold2;

    // Advance a stage when the next one is empty or moving
    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign s1_load = in_valid && s1_ready;
    assign s2_load = s1_valid_reg && s2_ready;
    assign s3_load = s2_valid_reg && s3_ready;

    assign s1_valid_next = s1_ready ? in_valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next = s3_ready ? s2_valid_reg : s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    // Classify the item and pick the new destination
    always_comb
    begin
        c_verdict = VERDICT_PASS;
        c_new_dst = '0;
        c_new_mac = '0;
        if (frame_length < MIN_FRAME_BYTES)
        begin
            c_verdict = VERDICT_DROP;
        end
        else if (ether_type != ETHER_IPV4)
        begin
            c_verdict = VERDICT_PASS;
        end
        else if (protocol == PROTO_ICMP)
        begin
            c_verdict = VERDICT_DROP;
        end
        else if (protocol != PROTO_TCP)
        begin
            c_verdict = VERDICT_PASS;
        end
        else if (src_addr == cfg.client_addr)
        begin
            c_verdict = VERDICT_TX;
            c_new_dst = pick_second ? cfg.backend_two_addr : cfg.backend_one_addr;
            c_new_mac = pick_second ? cfg.backend_two_mac_low : cfg.backend_one_mac_low;
        end
        else if (src_addr == cfg.backend_one_addr || src_addr == cfg.backend_two_addr)
        begin
            c_verdict = VERDICT_TX;
            c_new_dst = cfg.client_addr;
            c_new_mac = cfg.client_mac_low;
        end
    end

    // Sum the header words that the rewrite leaves alone
    assign c_psum = 19'(version_tos) + 19'(total_length) + 19'(ident)
                  + 19'(flags_fragment) + 19'({ttl, protocol});

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_verdict_reg <= c_verdict;
            s1_new_dst_reg <= c_new_dst;
            s1_new_mac_reg <= c_new_mac;
            s1_psum_reg    <= c_psum;
            s1_src_reg     <= src_addr;
            s1_dst_reg     <= dst_addr;
        end
    end

    // Rewrite addresses and add them into the sum
    assign s2_tx = (s1_verdict_reg == VERDICT_TX);
    assign c_sum = 20'(s1_psum_reg)
                 + 20'(cfg.balancer_addr[31:16]) + 20'(cfg.balancer_addr[15:0])
                 + 20'(s1_new_dst_reg[31:16])    + 20'(s1_new_dst_reg[15:0]);

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_verdict_reg <= s1_verdict_reg;
            s2_src_reg     <= s2_tx ? cfg.balancer_addr : s1_src_reg;
            s2_dst_reg     <= s2_tx ? s1_new_dst_reg : s1_dst_reg;
            s2_dmac_reg    <= s2_tx ? s1_new_mac_reg : 8'h00;
            s2_smac_reg    <= s2_tx ? cfg.balancer_mac_low : 8'h00;
            s2_sum_reg     <= c_sum;
        end
    end

    // Fold carries twice; the second fold cannot carry again
    assign c_fold1 = 17'(s2_sum_reg[15:0]) + 17'(s2_sum_reg[19:16]);
    assign c_fold2 = c_fold1[15:0] + 16'(c_fold1[16]);

    always_ff @(posedge clk)
    begin
        if (s3_load)
        begin
            s3_verdict_reg <= s2_verdict_reg;
            s3_src_reg     <= s2_src_reg;
            s3_dst_reg     <= s2_dst_reg;
            s3_dmac_reg    <= s2_dmac_reg;
            s3_smac_reg    <= s2_smac_reg;
            s3_csum_reg    <= (s2_verdict_reg == VERDICT_TX) ? ~c_fold2 : 16'h0000;
        end
    end

    assign out_valid       = s3_valid_reg;
    assign verdict         = s3_verdict_reg;
    assign out_src_addr    = s3_src_reg;
    assign out_dst_addr    = s3_dst_reg;
    assign dst_mac_low     = s3_dmac_reg;
    assign src_mac_low     = s3_smac_reg;
    assign header_checksum = s3_csum_reg;

endmodule

// ===== src/iplb_cfg.sv =====
// Configuration register file for the load-balancer header rewrite.
`timescale 1ns / 1ps

module iplb_cfg
    import iplb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BALANCER_ADDR:    cfg_next.balancer_addr       = cfg_data;
                REG_BACKEND_ONE_ADDR: cfg_next.backend_one_addr    = cfg_data;
                REG_BACKEND_TWO_ADDR: cfg_next.backend_two_addr    = cfg_data;
                REG_CLIENT_ADDR:      cfg_next.client_addr         = cfg_data;
                REG_BALANCER_MAC:     cfg_next.balancer_mac_low    = cfg_data[7:0];
                REG_BACKEND_ONE_MAC:  cfg_next.backend_one_mac_low = cfg_data[7:0];
                REG_BACKEND_TWO_MAC:  cfg_next.backend_two_mac_low = cfg_data[7:0];
                REG_CLIENT_MAC:       cfg_next.client_mac_low      = cfg_data[7:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers, load defaults on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.balancer_addr       <= RST_BALANCER_ADDR;
            cfg_reg.backend_one_addr    <= RST_BACKEND_ONE_ADDR;
            cfg_reg.backend_two_addr    <= RST_BACKEND_TWO_ADDR;
            cfg_reg.client_addr         <= RST_CLIENT_ADDR;
            cfg_reg.balancer_mac_low    <= RST_BALANCER_MAC;
            cfg_reg.backend_one_mac_low <= RST_BACKEND_ONE_MAC;
            cfg_reg.backend_two_mac_low <= RST_BACKEND_TWO_MAC;
            cfg_reg.client_mac_low      <= RST_CLIENT_MAC;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/iplb_checker.sv =====
// Port-level checker for the header rewrite, bound to the top level.
`timescale 1ns / 1ps

module iplb_checker
    import iplb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  verdict,
    input logic [31:0] out_src_addr,
    input logic [31:0] out_dst_addr,
    input logic [7:0]  dst_mac_low,
    input logic [7:0]  src_mac_low,
    input logic [15:0] header_checksum
);

    // Pipeline is empty once reset has been seen at an edge
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("out_valid high during reset");

    // A stalled result holds its verdict, addresses and checksum
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(verdict)
            && $stable(out_src_addr) && $stable(out_dst_addr)
            && $stable(header_checksum))
        else $error("stalled result changed");

    // Only defined verdict codes leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (verdict == VERDICT_DROP || verdict == VERDICT_PASS
            || verdict == VERDICT_TX))
        else $error("undefined verdict code");

    // Non-rewritten results carry zero MAC bytes and checksum
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict != VERDICT_TX |->
            dst_mac_low == 8'h00 && src_mac_low == 8'h00 && header_checksum == 16'h0000)
        else $error("rewrite fields set on a non-transmit verdict");

endmodule

bind ipv4_tcp_lb_header_rewrite iplb_checker u_iplb_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .verdict         (verdict),
    .out_src_addr    (out_src_addr),
    .out_dst_addr    (out_dst_addr),
    .dst_mac_low     (dst_mac_low),
    .src_mac_low     (src_mac_low),
    .header_checksum (header_checksum)
);
